FILE: sv/sljxr_pkg.sv
// Shared types and constants for the sync/length XOR frame receiver.
package sljxr_pkg;

	// Frame constants
	localparam logic [7:0]  SYNC_BYTE     = 8'hE6;
	localparam logic [7:0]  ACK_CMD       = 8'h02;
	localparam logic [7:0]  REQ_BILL      = 8'h16;
	localparam logic [7:0]  REQ_COIN      = 8'h17;
	localparam logic [15:0] TIMEOUT_RESET = 16'd20;
	localparam logic [7:0]  MIN_LENGTH    = 8'd4;

	// Item kinds
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_TICK = 2'd1;
	localparam logic [1:0] KIND_POLL = 2'd2;

	// Result status codes
	localparam logic [2:0] ST_PAYLOAD  = 3'd0;
	localparam logic [2:0] ST_GOOD     = 3'd1;
	localparam logic [2:0] ST_GOOD_NAK = 3'd2;
	localparam logic [2:0] ST_CSUM_ERR = 3'd3;
	localparam logic [2:0] ST_TIMEOUT  = 3'd4;
	localparam logic [2:0] ST_BAD_LEN  = 3'd5;

	// Byte positions within a frame
	localparam logic [7:0] POS_SYNC = 8'd0;
	localparam logic [7:0] POS_LEN  = 8'd1;
	localparam logic [7:0] POS_CMD  = 8'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
		logic [7:0] request_type;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		logic [7:0] command_code;
		logic       frame_end;
	} result_t;

endpackage

FILE: sv/sync_length_xor_frame_receiver.sv
// Top level: input register, frame logic and result register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  in      | in        | in_valid / in_ready   | req_type, rx_byte, request_type
//  out     | out       | out_valid / out_ready | status, data_byte, byte_index,
//          |           |                       | command_code, frame_end
//  cfg     | in        | cfg_wr_en             | cfg_wr_data (timeout_ticks)
//
// One item per cycle sustained while the output is not stalled; an accepted item waits in
// the input register while the frame logic feeds its result, if it makes one, to the
// result register. The frame state updates as an item leaves the input register.
// A stalled result holds the input register; in_ready drops only when both are full.
// Reset clears state, timeout to 20 ticks, and both valid flags.
module sync_length_xor_frame_receiver import sljxr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  request_type,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  data_byte,
	output logic [7:0]  byte_index,
	output logic [7:0]  command_code,
	output logic        frame_end,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	item_t   item_s1;
	logic    vld_s1;
	result_t res_q;
	logic    out_vld_q;
	result_t res;
	logic    res_vld;
	logic    fire;

	// advance the held item when the result register can take whatever it makes
	assign fire     = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || fire;

	sljxr_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (fire),
		.item        (item_s1),
		.res_vld     (res_vld),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_ready)
				vld_s1 <= in_valid;
			if (fire)
				out_vld_q <= res_vld;
			else if (out_ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.req_type     <= req_type;
			item_s1.rx_byte      <= rx_byte;
			item_s1.request_type <= request_type;
		end
		if (fire && res_vld)
			res_q <= res;
	end

	assign out_valid    = out_vld_q;
	assign status       = res_q.status;
	assign data_byte    = res_q.data_byte;
	assign byte_index   = res_q.byte_index;
	assign command_code = res_q.command_code;
	assign frame_end    = res_q.frame_end;

endmodule

FILE: sv/sljxr_core.sv
// Frame state, checksum and timeout logic; one item per cycle when fire is high.
module sljxr_core import sljxr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        fire,
	input  item_t       item,
	output logic        res_vld,
	output result_t     res
);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RECV = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  byte_count_q, byte_count_d;
	logic [7:0]  frame_length_q, frame_length_d;
	logic [7:0]  running_xor_q, running_xor_d;
	logic [7:0]  command_q, command_d;
	logic [15:0] ticks_left_q, ticks_left_d;
	logic [7:0]  pending_req_q, pending_req_d;
	logic [15:0] timeout_ticks_q;
	logic        ack_suppress;

	assign ack_suppress = (command_q == ACK_CMD) &&
		((pending_req_q == REQ_BILL) || (pending_req_q == REQ_COIN));

	always_comb begin
		phase_d        = phase_q;
		byte_count_d   = byte_count_q;
		frame_length_d = frame_length_q;
		running_xor_d  = running_xor_q;
		command_d      = command_q;
		ticks_left_d   = ticks_left_q;
		pending_req_d  = pending_req_q;
		res_vld        = 1'b0;
		res.status       = ST_PAYLOAD;
		res.data_byte    = 8'd0;
		res.byte_index   = byte_count_q;
		res.command_code = command_q;
		res.frame_end    = 1'b0;

		if (item.req_type == KIND_POLL) begin
			// restart: abandon any frame in progress
			phase_d        = PH_RECV;
			pending_req_d  = item.request_type;
			ticks_left_d   = timeout_ticks_q;
			byte_count_d   = 8'd0;
			frame_length_d = 8'd0;
			running_xor_d  = 8'd0;
			command_d      = 8'd0;
		end else if (phase_q == PH_RECV) begin
			case (item.req_type)
				KIND_BYTE: begin
					if (byte_count_q == POS_SYNC) begin
						if (item.rx_byte == SYNC_BYTE) begin
							running_xor_d = item.rx_byte;
							byte_count_d  = 8'd1;
						end
					end else if (byte_count_q == POS_LEN) begin
						frame_length_d = item.rx_byte;
						running_xor_d  = running_xor_q ^ item.rx_byte;
						byte_count_d   = 8'd2;
						if (item.rx_byte < MIN_LENGTH) begin
							phase_d        = PH_DONE;
							res_vld        = 1'b1;
							res.status     = ST_BAD_LEN;
							res.byte_index = POS_LEN;
							res.frame_end  = 1'b1;
						end
					end else if (byte_count_q >= frame_length_q) begin
						// checksum byte closes the frame
						phase_d       = PH_DONE;
						res_vld       = 1'b1;
						res.frame_end = 1'b1;
						if (item.rx_byte != running_xor_q)
							res.status = ST_CSUM_ERR;
						else if (ack_suppress)
							res.status = ST_GOOD_NAK;
						else
							res.status = ST_GOOD;
					end else begin
						running_xor_d = running_xor_q ^ item.rx_byte;
						byte_count_d  = byte_count_q + 8'd1;
						if (byte_count_q == POS_CMD)
							command_d = item.rx_byte;
						if (byte_count_q > POS_CMD) begin
							res_vld       = 1'b1;
							res.data_byte = item.rx_byte;
						end
					end
				end
				KIND_TICK: begin
					if (ticks_left_q <= 16'd1) begin
						ticks_left_d  = 16'd0;
						phase_d       = PH_DONE;
						res_vld       = 1'b1;
						res.status    = ST_TIMEOUT;
						res.frame_end = 1'b1;
					end else begin
						ticks_left_d = ticks_left_q - 16'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			byte_count_q    <= 8'd0;
			frame_length_q  <= 8'd0;
			running_xor_q   <= 8'd0;
			command_q       <= 8'd0;
			ticks_left_q    <= 16'd0;
			pending_req_q   <= 8'd0;
			timeout_ticks_q <= TIMEOUT_RESET;
		end else begin
			if (cfg_wr_en)
				timeout_ticks_q <= cfg_wr_data;
			if (fire) begin
				phase_q        <= phase_d;
				byte_count_q   <= byte_count_d;
				frame_length_q <= frame_length_d;
				running_xor_q  <= running_xor_d;
				command_q      <= command_d;
				ticks_left_q   <= ticks_left_d;
				pending_req_q  <= pending_req_d;
			end
		end
	end

	// A verdict always leaves the receiver done until the next poll
	a_verdict_done: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_vld && res.frame_end) |=> (phase_q == PH_DONE))
		else $error("verdict did not close the transaction");

	// Once the length is known the count never runs past it
	a_count_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RECV && byte_count_q >= 8'd2) |-> (byte_count_q <= frame_length_q))
		else $error("byte count ran past frame length");

	// Payload results only come from positions after the command byte
	a_payload_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld && !res.frame_end) |-> (res.byte_index > POS_CMD && res.status == ST_PAYLOAD))
		else $error("payload result at a header position");

	// Nothing is reported outside a receiving phase
	a_quiet_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_RECV) |-> !res_vld)
		else $error("result outside a transaction");

endmodule
